// ===== rtl/block_average_proximity_zone_macros.svh =====
// ----------------------------------------------------------------------------
// Block average proximity zone: assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_PROXIMITY_ZONE_MACROS_SVH
`define BLOCK_AVERAGE_PROXIMITY_ZONE_MACROS_SVH

// Same-cycle implication.
`define BAPZ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BAPZ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bapz_pkg.sv =====
// ----------------------------------------------------------------------------
// Block average proximity zone: package
// Widths, reset values, codes and the zone decision shared by the modules and interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package bapz_pkg;

   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int SAMPLE_FIELD_BITS = 16;
   localparam int AVG_BITS          = 16;
   localparam int ZONE_BITS         = 2;
   localparam int SUM_BITS          = 24;
   localparam int COUNT_BITS        = 8;
   localparam int QUO_BITS          = SUM_BITS - COUNT_BITS;
   localparam int DIGIT_BITS        = 4;
   localparam int NUM_DIGITS        = SUM_BITS / DIGIT_BITS;
   localparam int THRESH_BITS       = 16;
   localparam int CSR_DATA_BITS     = 16;
   localparam int CSR_INDEX_BITS    = 2;

   localparam logic [COUNT_BITS-1:0]  WINDOW_RESET = 8'd8;
   localparam logic [THRESH_BITS-1:0] STOP_RESET   = 16'd2500;
   localparam logic [THRESH_BITS-1:0] SLOW_RESET   = 16'd1300;
   localparam logic [THRESH_BITS-1:0] ERROR_RESET  = 16'd4096;

   typedef enum logic [ZONE_BITS-1:0] {
      ZONE_OK    = 2'd0,
      ZONE_SLOW  = 2'd1,
      ZONE_STOP  = 2'd2,
      ZONE_ERROR = 2'd3
   } zone_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_LENGTH  = 2'd0,
      CSR_STOP_THRESHOLD = 2'd1,
      CSR_SLOW_THRESHOLD = 2'd2,
      CSR_ERROR_LIMIT    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_CHECK,
      ST_DIV,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Ordered test: stop, then slow down, then ok, otherwise error.
   function automatic zone_type classify(
      input logic [AVG_BITS-1:0]    avg,
      input logic [THRESH_BITS-1:0] stop_thr,
      input logic [THRESH_BITS-1:0] slow_thr,
      input logic [THRESH_BITS-1:0] err_lim
   );
      zone_type zone;
      if (avg < err_lim && avg >= stop_thr) begin
         zone = ZONE_STOP;
      end else if (avg < stop_thr && avg >= slow_thr) begin
         zone = ZONE_SLOW;
      end else if (avg < slow_thr) begin
         zone = ZONE_OK;
      end else begin
         zone = ZONE_ERROR;
      end
      return zone;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bapz_if.sv =====
// ----------------------------------------------------------------------------
// Block average proximity zone: channel interfaces
// Valid/ready channels for sample beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bapz_req_if;
   import bapz_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [SAMPLE_FIELD_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface bapz_rsp_if;
   import bapz_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [AVG_BITS-1:0]  average;
   logic [ZONE_BITS-1:0] zone;
   modport source (output valid, output average, output zone, input ready);
   modport sink   (input valid, input average, input zone, output ready);
endinterface

`default_nettype wire

// ===== rtl/block_average_proximity_zone.sv =====
// ----------------------------------------------------------------------------
// Block average proximity zone
// Sums distance samples over a configurable window, divides by the number
// of samples summed and classifies the mean into ok / slow down / stop / error.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  req_bus   in    valid / ready    sample[15:0]
//  rsp_bus   out   valid / ready    average[15:0], zone[1:0]
//  csr_*     in    csr_wr_en        csr_index[1:0], csr_wdata[15:0]
//
//  A sample beat runs through the accept, the 4-bit serial adder over the
//  24-bit sum, and the window check. On the beat that closes a window the
//  radix-2 divider follows, one quotient bit per cycle, then the result
//  register load.
//  Synchronous reset restores the register defaults and clears the window.
//  A stalled result holds in the output register; the next sample is still
//  taken, and only a second finished window waits for the register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module block_average_proximity_zone #(
   parameter int SAMPLE_BITS = bapz_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   bapz_req_if.sink                              req_bus,
   bapz_rsp_if.source                            rsp_bus,
   input  logic                                  csr_wr_en,
   input  logic [bapz_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bapz_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import bapz_pkg::*;

   localparam int DIG_CNT_BITS = $clog2(NUM_DIGITS);

   // configuration
   logic [COUNT_BITS-1:0]  window_ff;
   logic [THRESH_BITS-1:0] stop_ff;
   logic [THRESH_BITS-1:0] slow_ff;
   logic [THRESH_BITS-1:0] error_ff;

   state_type              state_ff, state_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic                   carry_ff, carry_in;
   logic [DIG_CNT_BITS-1:0] dig_ff, dig_in;
   logic [COUNT_BITS-1:0]  taken_ff, taken_in;
   logic [SAMPLE_BITS-1:0] smp_ff, smp_in;

   logic                   rsp_valid_ff;
   logic [AVG_BITS-1:0]    avg_ff;
   zone_type               zone_ff;

   logic                   req_ready;
   logic                   div_start;
   logic                   load_rsp;
   logic                   rsp_free;
   logic [DIGIT_BITS:0]    nib;
   logic [COUNT_BITS-1:0]  count;
   logic [COUNT_BITS-1:0]  len_eff;

   div_status_type         div_status;
   logic [QUO_BITS-1:0]    quotient;

   bapz_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (taken_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         stop_ff   <= STOP_RESET;
         slow_ff   <= SLOW_RESET;
         error_ff  <= ERROR_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_WINDOW_LENGTH:  window_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_STOP_THRESHOLD: stop_ff   <= csr_wdata[THRESH_BITS-1:0];
            CSR_SLOW_THRESHOLD: slow_ff   <= csr_wdata[THRESH_BITS-1:0];
            CSR_ERROR_LIMIT:    error_ff  <= csr_wdata[THRESH_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_free = ~rsp_valid_ff | rsp_bus.ready;
   assign nib      = {1'b0, sum_ff[DIGIT_BITS-1:0]} + {1'b0, smp_ff[DIGIT_BITS-1:0]}
                     + {{DIGIT_BITS{1'b0}}, carry_ff};
   // a window never passes 255 beats, so this cannot wrap
   assign count    = taken_ff + 1'b1;
   assign len_eff  = (window_ff == '0) ? COUNT_BITS'(1) : window_ff;

   always_comb begin
      state_in  = state_ff;
      sum_in    = sum_ff;
      carry_in  = carry_ff;
      dig_in    = dig_ff;
      taken_in  = taken_ff;
      smp_in    = smp_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               smp_in   = req_bus.sample[SAMPLE_BITS-1:0];
               dig_in   = '0;
               carry_in = 1'b0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            // sum rotates right one digit per cycle, back in place after the last
            sum_in   = {nib[DIGIT_BITS-1:0], sum_ff[SUM_BITS-1:DIGIT_BITS]};
            carry_in = nib[DIGIT_BITS];
            smp_in   = smp_ff >> DIGIT_BITS;
            if (dig_ff == DIG_CNT_BITS'(NUM_DIGITS - 1)) begin
               taken_in = count;
               state_in = ST_CHECK;
            end else begin
               dig_in = dig_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            if (taken_ff < len_eff) begin
               state_in = ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV, ST_HOLD: begin
            if (state_ff == ST_HOLD || div_status.done) begin
               if (rsp_free) begin
                  load_rsp = 1'b1;
                  sum_in   = '0;
                  taken_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         carry_ff     <= 1'b0;
         dig_ff       <= '0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         carry_ff <= carry_in;
         dig_ff   <= dig_in;
         taken_ff <= taken_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in;
      if (load_rsp) begin
         avg_ff  <= quotient;
         zone_ff <= classify(quotient, stop_ff, slow_ff, error_ff);
      end
   end

   assign req_bus.ready   = req_ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.average = avg_ff;
   assign rsp_bus.zone    = zone_ff;

endmodule

`default_nettype wire

// ===== rtl/bapz_div.sv =====
// ----------------------------------------------------------------------------
// Block average proximity zone: serial divider
// Restoring radix-2 divider, one quotient bit per cycle. The caller guarantees
// the quotient fits QUO_BITS, so the top COUNT_BITS of the dividend seed the
// partial remainder directly.
// ----------------------------------------------------------------------------
`default_nettype none

module bapz_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [bapz_pkg::SUM_BITS-1:0]      dividend,
   input  logic [bapz_pkg::COUNT_BITS-1:0]    divisor,
   output bapz_pkg::div_status_type           status,
   output logic [bapz_pkg::QUO_BITS-1:0]      quotient
);
   import bapz_pkg::*;

   localparam int STEP_BITS = $clog2(QUO_BITS);

   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0]   shr_ff, shr_in;
   logic [COUNT_BITS-1:0] dsr_ff, dsr_in;
   logic [STEP_BITS-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [COUNT_BITS:0]   trial;
   logic [COUNT_BITS:0]   diff;
   logic                  fits;

   assign trial = {rem_ff, shr_ff[QUO_BITS-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = ~diff[COUNT_BITS];

   always_comb begin
      rem_in  = rem_ff;
      shr_in  = shr_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[SUM_BITS-1:QUO_BITS];
         shr_in  = dividend[QUO_BITS-1:0];
         dsr_in  = divisor;
         cnt_in  = STEP_BITS'(QUO_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         shr_in = {shr_ff[QUO_BITS-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shr_ff <= shr_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = shr_ff;

endmodule

`default_nettype wire

// ===== rtl/bapz_chk.sv =====
// ----------------------------------------------------------------------------
// Block average proximity zone: port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_average_proximity_zone_macros.svh"

module bapz_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [bapz_pkg::AVG_BITS-1:0]   rsp_average,
   input logic [bapz_pkg::ZONE_BITS-1:0]  rsp_zone
);
   import bapz_pkg::*;

   `BAPZ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped while stalled")
   `BAPZ_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_average) && $stable(rsp_zone), "stalled result changed")
   `BAPZ_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && req_ready, !req_ready, "sample taken while previous still summing")
   `BAPZ_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "result raised straight after a sample beat")

endmodule

bind block_average_proximity_zone bapz_chk u_bapz_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_average (rsp_bus.average),
   .rsp_zone    (rsp_bus.zone)
);

`default_nettype wire
